// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps

package lcs_pkg;

	// Field widths of the ports
	localparam int CH_W        = 3;
	localparam int RAW_FIELD_W = 10;
	localparam int IDX_W       = 3;
	localparam int SCALE_W     = 7;
	localparam int LEVEL_W     = 15;
	localparam int DAMP_W      = 16;

	// Default sizes of the unit
	localparam int CHANNELS_DEF = 6;
	localparam int POINTS_DEF   = 5;
	localparam int RAW_BITS_DEF = 10;

	localparam logic [DAMP_W-1:0]  DAMP_RESET = 16'd62259;
	localparam logic [SCALE_W-1:0] PCT_MAX    = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'd25600;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Serial step counts: multiply then divide, radix-4 smoother
	localparam int INTERP_STEPS = 2 * SCALE_W;
	localparam int SMOOTH_STEPS = DAMP_W / 2;

	// Built-in calibration, one row per lever channel
	localparam int DEF_ROWS = 6;
	localparam int DEF_COLS = 5;

	localparam logic [RAW_FIELD_W-1:0] DEF_BREAK [DEF_ROWS][DEF_COLS] = '{
		'{10'd0,   10'd56,  10'd100, 10'd132, 10'd141},
		'{10'd0,   10'd80,  10'd167, 10'd243, 10'd284},
		'{10'd0,   10'd51,  10'd163, 10'd226, 10'd279},
		'{10'd0,   10'd58,  10'd139, 10'd205, 10'd346},
		'{10'd250, 10'd870, 10'd911, 10'd920, 10'd935},
		'{10'd0,   10'd5,   10'd23,  10'd48,  10'd65}
	};

	localparam logic [SCALE_W-1:0] DEF_SCALE [DEF_COLS] = '{
		7'd0, 7'd25, 7'd50, 7'd75, 7'd100
	};

	typedef struct packed {
		logic               done;
		logic [SCALE_W-1:0] pct;
	} interp_rsp_t;

	typedef struct packed {
		logic               start;
		logic [CH_W-1:0]    ch;
		logic [SCALE_W-1:0] pct;
	} smooth_req_t;

	typedef struct packed {
		logic               done;
		logic [SCALE_W-1:0] pct;
		logic [LEVEL_W-1:0] level;
	} smooth_rsp_t;

	// Extra channels reuse row (ch mod 6), extra points repeat the last column
	function automatic logic [RAW_FIELD_W-1:0] def_break(input logic [CH_W-1:0] ch,
			input logic [3:0] pt);
		logic [CH_W-1:0] row;
		logic [2:0]      col;
		row = (ch >= CH_W'(DEF_ROWS)) ? ch - CH_W'(DEF_ROWS) : ch;
		col = (pt < 4'(DEF_COLS)) ? pt[2:0] : 3'(DEF_COLS - 1);
		return DEF_BREAK[row][col];
	endfunction

	function automatic logic [SCALE_W-1:0] def_scale(input logic [3:0] pt);
		logic [2:0] col;
		col = (pt < 4'(DEF_COLS)) ? pt[2:0] : 3'(DEF_COLS - 1);
		return DEF_SCALE[col];
	endfunction

endpackage

// ===== hw/rtl/lcs_table.sv =====
`timescale 1ns / 1ps

module lcs_table #(
	parameter int CHANNELS = lcs_pkg::CHANNELS_DEF,
	parameter int POINTS   = lcs_pkg::POINTS_DEF,
	parameter int RAW_W    = lcs_pkg::RAW_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [lcs_pkg::CH_W-1:0]     wr_ch,
	input  logic [$clog2(POINTS)-1:0]    wr_pt,
	input  logic [RAW_W-1:0]             wr_bp,
	input  logic [lcs_pkg::SCALE_W-1:0]  wr_sc,
	input  logic [lcs_pkg::CH_W-1:0]     rd_ch,
	input  logic [$clog2(POINTS)-1:0]    rd_pt,
	output logic [RAW_W-1:0]             rd_bp,
	output logic [lcs_pkg::SCALE_W-1:0]  rd_sc
);
	import lcs_pkg::*;

	localparam int DEPTH  = CHANNELS * POINTS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ENT_W  = RAW_W + SCALE_W;

	logic [ENT_W-1:0]   mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENT_W-1:0]   ent_s1;
	logic               vld_s1;
	logic [RAW_W-1:0]   def_bp_s1;
	logic [SCALE_W-1:0] def_sc_s1;

	assign wr_addr = ADDR_W'(int'(wr_ch) * POINTS + int'(wr_pt));
	assign rd_addr = ADDR_W'(int'(rd_ch) * POINTS + int'(rd_pt));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_bp, wr_sc};
		end
		ent_s1    <= mem[rd_addr];
		vld_s1    <= vld_q[rd_addr];
		def_bp_s1 <= RAW_W'(def_break(rd_ch, 4'(rd_pt)));
		def_sc_s1 <= def_scale(4'(rd_pt));
	end

	// An entry never loaded reads as its built-in calibration point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign {rd_bp, rd_sc} = vld_s1 ? ent_s1 : {def_bp_s1, def_sc_s1};

endmodule

// ===== hw/rtl/lcs_interp.sv =====
`timescale 1ns / 1ps

module lcs_interp #(
	parameter int RAW_W = lcs_pkg::RAW_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [RAW_W-1:0]            raw,
	input  logic [RAW_W-1:0]            vl,
	input  logic [RAW_W-1:0]            vu,
	input  logic [lcs_pkg::SCALE_W-1:0] sl,
	input  logic [lcs_pkg::SCALE_W-1:0] su,
	output lcs_pkg::interp_rsp_t        rsp
);
	import lcs_pkg::*;

	localparam int NUM_W = RAW_W + SCALE_W;
	localparam int CNT_W = $clog2(INTERP_STEPS);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SCALE_W-1:0]        mag_q;
	logic [SCALE_W-1:0]        q_q;
	logic [SCALE_W-1:0]        base_q;
	logic [SCALE_W-1:0]        pct_q;
	logic                      neg_q;
	logic [RAW_W-1:0]          w_q;
	logic [NUM_W-1:0]          acc_q;
	logic [NUM_W-1:0]          dsh_q;
	logic signed [SCALE_W:0]   diff;
	logic                      mul_phase;
	logic                      last;
	logic                      fits;
	logic [SCALE_W-1:0]        q_next;

	assign diff      = $signed({1'b0, su}) - $signed({1'b0, sl});
	assign mul_phase = cnt_q < CNT_W'(SCALE_W);
	assign last      = cnt_q == CNT_W'(INTERP_STEPS - 1);
	assign fits      = acc_q >= dsh_q;
	assign q_next    = {q_q[SCALE_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add multiply of |su-sl| by (raw-vl), MSB first, then restoring
	// divide by (vu-vl); the quotient stays below |su-sl| so seven bits do.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= diff[SCALE_W] ? SCALE_W'(-diff) : diff[SCALE_W-1:0];
			neg_q  <= diff[SCALE_W];
			base_q <= sl;
			w_q    <= raw - vl;
			acc_q  <= '0;
			dsh_q  <= NUM_W'(vu - vl) << (SCALE_W - 1);
			q_q    <= '0;
		end else if (busy_q) begin
			if (mul_phase) begin
				acc_q <= {acc_q[NUM_W-2:0], 1'b0} + (mag_q[SCALE_W-1] ? NUM_W'(w_q) : '0);
				mag_q <= {mag_q[SCALE_W-2:0], 1'b0};
			end else begin
				if (fits) begin
					acc_q <= acc_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				q_q   <= q_next;
				if (last) begin
					pct_q <= neg_q ? base_q - q_next : base_q + q_next;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.pct  = pct_q;

endmodule

// ===== hw/rtl/lcs_smooth.sv =====
`timescale 1ns / 1ps

module lcs_smooth #(
	parameter int CHANNELS = lcs_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcs_pkg::smooth_req_t        req,
	input  logic [lcs_pkg::DAMP_W-1:0]  damping,
	output lcs_pkg::smooth_rsp_t        rsp
);
	import lcs_pkg::*;

	localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ACC_W    = DAMP_W + 3;
	localparam int CNT_W    = $clog2(SMOOTH_STEPS);

	logic [LEVEL_W-1:0]       filt_q [CHANNELS];
	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_BITS-1:0]      idx_q;
	logic [LEVEL_W-1:0]       x_q;
	logic [SCALE_W-1:0]       pct_q;
	logic [DAMP_W-1:0]        d_q;
	logic signed [DAMP_W-1:0] diff_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [LEVEL_W-1:0]       level_q;
	logic [IDX_BITS-1:0]      req_idx;
	logic [LEVEL_W-1:0]       x_in;
	logic signed [DAMP_W-1:0] diff;
	logic signed [ACC_W-1:0]  d1;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  acc_next;
	logic [ACC_W-1:0]         y;
	logic                     last;

	assign req_idx = IDX_BITS'(req.ch);
	assign x_in    = {req.pct, 8'b0};
	assign diff    = $signed({1'b0, filt_q[req_idx]}) - $signed({1'b0, x_in});
	assign last    = cnt_q == CNT_W'(SMOOTH_STEPS - 1);

	// y = x + floor((f - x) * d / 2^16), two bits of d a step, LSB first
	always_comb begin
		d1 = ACC_W'(diff_q);
		case (d_q[1:0])
			2'd0:    addend = '0;
			2'd1:    addend = d1;
			2'd2:    addend = d1 <<< 1;
			default: addend = d1 + (d1 <<< 1);
		endcase
		sum      = acc_q + addend;
		acc_next = sum >>> 2;
		y        = ACC_W'($unsigned(acc_next)) + ACC_W'(x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				filt_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q        <= 1'b0;
					done_q        <= 1'b1;
					filt_q[idx_q] <= y[LEVEL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			idx_q  <= req_idx;
			x_q    <= x_in;
			pct_q  <= req.pct;
			d_q    <= damping;
			diff_q <= diff;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			d_q   <= d_q >> 2;
			if (last) begin
				level_q <= y[LEVEL_W-1:0];
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.pct   = pct_q;
	assign rsp.level = level_q;

endmodule

// ===== hw/rtl/lever_calibrate_and_smooth_unit.sv =====
`timescale 1ns / 1ps
// A sample scans the table points in order, one per table read, until one closes its segment or
// the row ends; a clamped sample then goes straight to the smoother, an interpolated one first
// through the serial 7-step multiply plus 7-step divide, then the 8-step radix-4 smoother.
// One item at a time: no new beat is taken until the sample's result is in the output register.
// Loads, and samples for channels out of range, leave the unit idle and give no result.
// Reset: damping 0.95, filters zero, table reads the built-in calibration; no clearing pass.
module lever_calibrate_and_smooth_unit #(
	parameter int CHANNELS = lcs_pkg::CHANNELS_DEF,
	parameter int POINTS   = lcs_pkg::POINTS_DEF,
	parameter int RAW_BITS = lcs_pkg::RAW_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lcs_pkg::DAMP_W-1:0]      cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [lcs_pkg::CH_W-1:0]        channel,
	input  logic [lcs_pkg::RAW_FIELD_W-1:0] raw_value,
	input  logic [lcs_pkg::IDX_W-1:0]       point_index,
	input  logic [lcs_pkg::SCALE_W-1:0]     point_scale,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lcs_pkg::CH_W-1:0]        out_channel,
	output logic [lcs_pkg::SCALE_W-1:0]     linear_percent,
	output logic [lcs_pkg::LEVEL_W-1:0]     smoothed_level
);
	import lcs_pkg::*;

	// Raw readings pass through a 10-bit field, so the stored width never exceeds it
	localparam int RW   = (RAW_BITS < RAW_FIELD_W) ? RAW_BITS : RAW_FIELD_W;
	localparam int PT_W = $clog2(POINTS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_INTERP = 5'b00100,
		ST_SMOOTH = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [DAMP_W-1:0]  damping_q;
	logic [CH_W-1:0]    ch_q;
	logic [RW-1:0]      raw_q;
	logic [PT_W-1:0]    pidx_q;
	logic [RW-1:0]      prev_bp_q;
	logic [SCALE_W-1:0] prev_sc_q;
	logic               out_valid_q;
	logic [CH_W-1:0]    out_channel_q;
	logic [SCALE_W-1:0] linear_percent_q;
	logic [LEVEL_W-1:0] smoothed_level_q;

	logic               accept;
	logic               ch_ok;
	logic               take_sample;
	logic               do_load;
	logic [SCALE_W-1:0] load_sc;
	logic [CH_W-1:0]    rd_ch;
	logic [PT_W-1:0]    rd_pt;
	logic [PT_W-1:0]    pidx_nx;
	logic [RW-1:0]      ent_bp;
	logic [SCALE_W-1:0] ent_sc;
	logic               below;
	logic               at_end;
	logic               clamp_go;
	logic               interp_go;
	logic               out_free;
	logic               out_load;
	interp_rsp_t        interp_rsp;
	smooth_req_t        smooth_req;
	smooth_rsp_t        smooth_rsp;

	// ---------------------------------------------------------------- input side
	// Take a beat only when idle; the output register lets a new beat in while
	// the previous result still waits downstream.
	assign in_stall    = state_q != ST_IDLE;
	assign accept      = in_valid && !in_stall;
	assign ch_ok       = int'(channel) < CHANNELS;
	assign take_sample = accept && ch_ok && (command == CMD_SAMPLE);
	assign do_load     = accept && ch_ok && (command == CMD_LOAD) && (int'(point_index) < POINTS);
	assign load_sc     = (point_scale > PCT_MAX) ? PCT_MAX : point_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q <= DAMP_RESET;
		end else if (cfg_wr_en) begin
			damping_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------- table
	// Read point 0 on the accept cycle, then the next point every scan cycle.
	assign pidx_nx = (pidx_q == PT_W'(POINTS - 1)) ? pidx_q : pidx_q + 1'b1;
	assign rd_ch   = (state_q == ST_SCAN) ? ch_q : channel;
	assign rd_pt   = (state_q == ST_SCAN) ? pidx_nx : '0;

	lcs_table #(
		.CHANNELS (CHANNELS),
		.POINTS   (POINTS),
		.RAW_W    (RW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (do_load),
		.wr_ch  (channel),
		.wr_pt  (PT_W'(point_index)),
		.wr_bp  (RW'(raw_value)),
		.wr_sc  (load_sc),
		.rd_ch  (rd_ch),
		.rd_pt  (rd_pt),
		.rd_bp  (ent_bp),
		.rd_sc  (ent_sc)
	);

	// ---------------------------------------------------------------- scan
	// The first point whose breakpoint exceeds the reading closes the segment.
	// Below the first point, or past the last one, take that point's percent.
	assign below     = raw_q < ent_bp;
	assign at_end    = pidx_q == PT_W'(POINTS - 1);
	assign clamp_go  = (state_q == ST_SCAN) && ((below && (pidx_q == '0)) || (!below && at_end));
	assign interp_go = (state_q == ST_SCAN) && below && (pidx_q != '0);

	lcs_interp #(
		.RAW_W (RW)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (interp_go),
		.raw    (raw_q),
		.vl     (prev_bp_q),
		.vu     (ent_bp),
		.sl     (prev_sc_q),
		.su     (ent_sc),
		.rsp    (interp_rsp)
	);

	// ---------------------------------------------------------------- smoother
	assign smooth_req.start = clamp_go || ((state_q == ST_INTERP) && interp_rsp.done);
	assign smooth_req.ch    = ch_q;
	assign smooth_req.pct   = clamp_go ? ent_sc : interp_rsp.pct;

	lcs_smooth #(
		.CHANNELS (CHANNELS)
	) u_smooth (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (smooth_req),
		.damping (damping_q),
		.rsp     (smooth_rsp)
	);

	// ---------------------------------------------------------------- sequencer
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = ((state_q == ST_SMOOTH) && smooth_rsp.done || (state_q == ST_EMIT))
		&& out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_sample) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (clamp_go) begin
					state_d = ST_SMOOTH;
				end else if (interp_go) begin
					state_d = ST_INTERP;
				end
			end
			ST_INTERP: begin
				if (interp_rsp.done) state_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				// Hold the result in the smoother while the output register is full
				if (smooth_rsp.done) state_d = out_free ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_sample) begin
				pidx_q <= '0;
			end else if ((state_q == ST_SCAN) && !clamp_go && !interp_go) begin
				pidx_q <= pidx_q + 1'b1;
			end
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			ch_q  <= channel;
			raw_q <= RW'(raw_value);
		end
		// Keep the point just passed as the lower end of the next segment
		if (state_q == ST_SCAN) begin
			prev_bp_q <= ent_bp;
			prev_sc_q <= ent_sc;
		end
		if (out_load) begin
			out_channel_q    <= ch_q;
			linear_percent_q <= smooth_rsp.pct;
			smoothed_level_q <= smooth_rsp.level;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_channel    = out_channel_q;
	assign linear_percent = linear_percent_q;
	assign smoothed_level = smoothed_level_q;

	// ---------------------------------------------------------------- checks
	a_interp_done_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		interp_rsp.done |-> state_q == ST_INTERP)
		else $error("interpolator finished outside its state");

	a_smooth_done_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_rsp.done |-> state_q == ST_SMOOTH)
		else $error("smoother finished outside its state");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_LOAD)) |=> state_q == ST_IDLE)
		else $error("table load started a sample sequence");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (linear_percent <= PCT_MAX) && (smoothed_level <= LEVEL_MAX))
		else $error("result beat out of range");

endmodule

// ===== dv/lever_calibrate_and_smooth_unit_tb.sv =====
`timescale 1ns / 1ps

module lever_calibrate_and_smooth_unit_tb;
	import lcs_pkg::*;

	localparam int N_CH          = CHANNELS_DEF;
	localparam int N_PT          = POINTS_DEF;
	localparam int RAW_MAX       = (1 << RAW_BITS_DEF) - 1;
	// Margin after the last reading for loads still in flight
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int BEATS_PER_SET = 110;

	typedef struct {
		logic [CH_W-1:0]    ch;
		logic [SCALE_W-1:0] pct;
		logic [LEVEL_W-1:0] level;
	} lever_reading_t;

	// Shadow of the calibration tables and per-channel filters; predicts each reading
	class lever_scoreboard;
		logic [RAW_FIELD_W-1:0] brk   [N_CH*N_PT];
		logic [SCALE_W-1:0]     scale [N_CH*N_PT];
		logic [LEVEL_W-1:0]     level [N_CH];
		logic [DAMP_W-1:0]      damping;
		lever_reading_t         expected_readings [$];
		int mismatches, samples, loads, ignored, checked;

		function new();
			damping = DAMP_RESET;
			for (int c = 0; c < N_CH; c++) begin
				level[c] = '0;
				for (int p = 0; p < N_PT; p++) begin
					brk[c*N_PT+p]   = DEF_BREAK[c % DEF_ROWS][p];
					scale[c*N_PT+p] = DEF_SCALE[p];
				end
			end
		endfunction

		// Walk the row in order; first segment whose upper point exceeds the reading wins
		function logic [SCALE_W-1:0] interpolate_percent(int base, int v);
			longint lo_pct, hi_pct, lo_raw, hi_raw;
			if (v < int'(brk[base]))
				return scale[base];
			for (int i = 0; i + 1 < N_PT; i++) begin
				if (v < int'(brk[base+i+1])) begin
					lo_pct = scale[base+i];
					hi_pct = scale[base+i+1];
					lo_raw = brk[base+i];
					hi_raw = brk[base+i+1];
					if (hi_raw <= lo_raw)
						return scale[base+i];
					// signed divide truncates toward zero, as falling rows need
					return SCALE_W'(lo_pct + (hi_pct - lo_pct) * (v - lo_raw) / (hi_raw - lo_raw));
				end
			end
			return scale[base+N_PT-1];
		endfunction

		function void note_beat(logic cmd, logic [CH_W-1:0] ch, logic [RAW_FIELD_W-1:0] raw,
				logic [IDX_W-1:0] idx, logic [SCALE_W-1:0] scl);
			int base;
			longint d, acc;
			lever_reading_t r;
			if (ch >= N_CH) begin
				ignored++;
				return;
			end
			base = ch * N_PT;
			if (cmd == CMD_LOAD) begin
				if (idx < N_PT) begin
					brk[base+idx]   = raw;
					scale[base+idx] = (scl > PCT_MAX) ? PCT_MAX : scl;
					loads++;
				end else
					ignored++;
				return;
			end
			samples++;
			r.ch  = ch;
			r.pct = interpolate_percent(base, int'(raw));
			d     = damping;
			acc   = longint'(level[ch]) * d + longint'(r.pct) * 256 * (65536 - d);
			level[ch] = LEVEL_W'(acc >>> 16);
			r.level   = level[ch];
			expected_readings.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 60)
				$display("MISMATCH: %s", msg);
		endtask

		task check_reading(logic [CH_W-1:0] ch, logic [SCALE_W-1:0] pct,
				logic [LEVEL_W-1:0] lvl);
			lever_reading_t e;
			if (expected_readings.size() == 0) begin
				report($sformatf("reading with nothing pending: ch %0d pct %0d level %0d",
					ch, pct, lvl));
				return;
			end
			e = expected_readings.pop_front();
			checked++;
			if (ch !== e.ch)
				report($sformatf("out_channel %0d, want %0d", ch, e.ch));
			if (pct !== e.pct)
				report($sformatf("ch %0d linear_percent %0d, want %0d", e.ch, pct, e.pct));
			if (lvl !== e.level)
				report($sformatf("ch %0d smoothed_level %0d, want %0d", e.ch, lvl, e.level));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [DAMP_W-1:0]      cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   command;
	logic [CH_W-1:0]        channel;
	logic [RAW_FIELD_W-1:0] raw_value;
	logic [IDX_W-1:0]       point_index;
	logic [SCALE_W-1:0]     point_scale;
	logic                   out_valid;
	logic                   out_stall;
	logic [CH_W-1:0]        out_channel;
	logic [SCALE_W-1:0]     linear_percent;
	logic [LEVEL_W-1:0]     smoothed_level;

	// Gap-free stretches on either side, reshuffled as the run goes
	bit in_calm  = 1'b0;
	bit out_calm = 1'b0;
	int cycles   = 0;
	int settings_done = 0;

	lever_scoreboard sb = new;

	lever_calibrate_and_smooth_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.channel        (channel),
		.raw_value      (raw_value),
		.point_index    (point_index),
		.point_scale    (point_scale),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_channel    (out_channel),
		.linear_percent (linear_percent),
		.smoothed_level (smoothed_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run; a hang anywhere ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d readings pending", cycles,
				sb.expected_readings.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sample both handshakes before this edge's updates land
	always @(posedge clk) begin
		if (arst_n && in_valid === 1'b1 && in_stall === 1'b0)
			sb.note_beat(command, channel, raw_value, point_index, point_scale);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_reading(out_channel, linear_percent, smoothed_level);
	end

	// Result side: draw a stall before each reading, stall even when nothing is offered
	initial begin : result_sink
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = out_calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Hold off a random gap, present the beat, hold it until taken
	task automatic drive_beat(input logic cmd, input logic [CH_W-1:0] ch,
			input logic [RAW_FIELD_W-1:0] raw, input logic [IDX_W-1:0] idx,
			input logic [SCALE_W-1:0] scl);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		channel     <= ch;
		raw_value   <= raw;
		point_index <= idx;
		point_scale <= scl;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	// Wait out every pending reading, then let trailing loads finish too
	task automatic drain_results();
		do @(posedge clk); while (sb.expected_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only call with the unit idle
	task automatic write_damping(input logic [DAMP_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.damping = value;
		settings_done++;
	endtask

	task automatic directed_beats();
		// clamp at both ends, exact breakpoints, plain interpolation
		drive_beat(CMD_SAMPLE, 3'd0, 10'd0,    3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd4, 10'd0,    3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd0, 10'd1023, 3'd7, 7'd127);
		drive_beat(CMD_SAMPLE, 3'd0, 10'd141,  3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd0, 10'd78,   3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd4, 10'd900,  3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd3, 10'd345,  3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd1, 10'd80,   3'd0, 7'd0);
		// channel out of range, point index out of range: dropped
		drive_beat(CMD_SAMPLE, 3'd6, 10'd512,  3'd0, 7'd0);
		drive_beat(CMD_LOAD,   3'd7, 10'd1023, 3'd7, 7'd127);
		drive_beat(CMD_LOAD,   3'd1, 10'd1023, 3'd5, 7'd127);
		drive_beat(CMD_LOAD,   3'd1, 10'd0,    3'd7, 7'd50);
		// percent above 100 saturates; row left out of order
		drive_beat(CMD_LOAD,   3'd5, 10'd1023, 3'd2, 7'd127);
		drive_beat(CMD_SAMPLE, 3'd5, 10'd30,   3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd5, 10'd1023, 3'd0, 7'd0);
		// falling percents along a segment
		drive_beat(CMD_LOAD,   3'd2, 10'd0,    3'd0, 7'd100);
		drive_beat(CMD_LOAD,   3'd2, 10'd51,   3'd1, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd2, 10'd20,   3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd2, 10'd50,   3'd0, 7'd0);
		drive_beat(CMD_LOAD,   3'd3, 10'd0,    3'd4, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd3, 10'd0,    3'd0, 7'd0);
		drive_beat(CMD_SAMPLE, 3'd3, 10'd512,  3'd7, 7'd127);
	endtask

	task automatic random_beat();
		int pick, ch, k, raw, lo, hi, lo_s, hi_s, base;
		pick = $urandom_range(0, 99);
		ch   = $urandom_range(0, N_CH - 1);
		k    = $urandom_range(0, N_PT - 1);
		base = ch * N_PT;
		if (pick < 6) begin
			// noise: channels past the last lever, either command
			drive_beat(1'($urandom_range(0, 1)), CH_W'($urandom_range(N_CH, 7)),
				RAW_FIELD_W'($urandom), IDX_W'($urandom), SCALE_W'($urandom));
		end else if (pick < 10) begin
			drive_beat(CMD_LOAD, CH_W'(ch), RAW_FIELD_W'($urandom),
				IDX_W'($urandom_range(N_PT, 7)), SCALE_W'($urandom));
		end else if (pick < 15) begin
			// retune one point between its neighbors so the row stays usable
			lo   = (k > 0) ? int'(sb.brk[base+k-1]) : 0;
			hi   = (k < N_PT - 1) ? int'(sb.brk[base+k+1]) : RAW_MAX;
			lo_s = (k > 0) ? int'(sb.scale[base+k-1]) : 0;
			hi_s = (k < N_PT - 1) ? int'(sb.scale[base+k+1]) : int'(PCT_MAX);
			raw  = $urandom_range(lo, hi);
			drive_beat(CMD_LOAD, CH_W'(ch), RAW_FIELD_W'(raw), IDX_W'(k),
				SCALE_W'($urandom_range(lo_s, hi_s)));
		end else if (pick < 18) begin
			drive_beat(CMD_LOAD, CH_W'(ch), RAW_FIELD_W'($urandom), IDX_W'(k),
				SCALE_W'($urandom));
		end else if (pick < 60) begin
			// land on or next to a breakpoint
			raw = int'(sb.brk[base+k]) + int'($urandom_range(0, 6)) - 3;
			if (raw < 0)
				raw = 0;
			if (raw > RAW_MAX)
				raw = RAW_MAX;
			drive_beat(CMD_SAMPLE, CH_W'(ch), RAW_FIELD_W'(raw), IDX_W'($urandom),
				SCALE_W'($urandom));
		end else begin
			drive_beat(CMD_SAMPLE, CH_W'(ch), RAW_FIELD_W'($urandom_range(0, RAW_MAX)),
				IDX_W'($urandom), SCALE_W'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [DAMP_W-1:0] damping_sets [7];
		damping_sets = '{DAMP_RESET, 16'd0, 16'hFFFF, 16'h8000, 16'd1,
			DAMP_W'($urandom), DAMP_W'($urandom)};
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		command     <= CMD_SAMPLE;
		channel     <= '0;
		raw_value   <= '0;
		point_index <= '0;
		point_scale <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed corners run on the reset damping
		directed_beats();

		foreach (damping_sets[p]) begin
			// Drain fully before touching the damping register
			release_input();
			drain_results();
			write_damping(damping_sets[p]);
			for (int n = 0; n < BEATS_PER_SET; n++) begin
				if (n % 40 == 0) begin
					in_calm  = ($urandom_range(0, 3) == 0);
					out_calm = ($urandom_range(0, 3) == 0);
				end
				// Now and then starve the unit until it has emptied
				if ($urandom_range(0, 79) == 0) begin
					release_input();
					drain_results();
				end
				random_beat();
			end
		end

		release_input();
		drain_results();

		if (sb.expected_readings.size() != 0)
			sb.report($sformatf("%0d readings never arrived", sb.expected_readings.size()));
		$display("Covered %0d samples, %0d table loads and %0d dropped beats over %0d damping values",
			sb.samples, sb.loads, sb.ignored, settings_done + 1);
		$display("Checked %0d readings, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_table.sv
hw/rtl/lcs_interp.sv
hw/rtl/lcs_smooth.sv
hw/rtl/lever_calibrate_and_smooth_unit.sv
dv/lever_calibrate_and_smooth_unit_tb.sv
